/* design/sac_pkg.sv */
// Shared types and constants for the sliding anagram counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sac_pkg;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned COUNT_W  = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_TEXT    = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]          action;
    logic [LETTER_W-1:0] letter;
  } sac_in_t;

  typedef struct packed {
    logic               window_full;
    logic               is_match;
    logic [COUNT_W-1:0] match_count;
  } sac_out_t;

  // per-letter strobes broadcast to the cell row
  typedef struct packed {
    logic clear;
    logic pat_add;
    logic win_add;
    logic win_sub;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* design/sliding_anagram_counter.sv */
// Top level of the sliding anagram counter: control, letter cell row, ring.
// Depends on sac_pkg, sac_cell and sac_ring.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (action, letter)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (full, match, count)
//
// Throughput: one item per cycle while the output is not stalled, any mix of clear, pattern and text.
// A text item's cells and middle stage load on its accepting edge; its match
// and count load the output register when the middle stage moves on to a
// free output.
// The leaving letter is read ahead from the registered ring read port at the
// address the next item will need; a one-letter pattern takes it from a bypass register.
// Reset clears all control and the cell row at once; the ring needs no sweep.
// A stalled output holds the pending text item in the middle stage; input
// ready drops only when both stages are occupied and the output is stalled.
`timescale 1ns / 1ps
`default_nettype none

module sliding_anagram_counter import sac_pkg::*; #(
  parameter int unsigned MAX_PATTERN   = 1024,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire sac_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output sac_out_t      out_data_o
);

  // length and fill hold 0..MAX_PATTERN, the ring pointer 0..MAX_PATTERN-1
  localparam int unsigned LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int unsigned RING_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned CALC_W = LEN_W + 1;

  // ---------------------------------------------------------------- decode
  logic in_go, letter_ok, is_clear, is_pat, is_text;
  logic pat_go, text_go, text_live, win_full_now, slide;

  assign in_go     = in_valid_i & in_ready_o;
  assign letter_ok = 32'(in_data_i.letter) < ALPHABET_SIZE;
  assign is_clear  = in_data_i.action == ACT_CLEAR;
  assign is_pat    = (in_data_i.action == ACT_PATTERN) & letter_ok;
  assign is_text   = (in_data_i.action == ACT_TEXT) & letter_ok;

  logic [LEN_W-1:0]    plen_q, plen_d;
  logic [LEN_W-1:0]    fill_q, fill_d;
  logic [RING_W-1:0]   ring_q, ring_d;
  logic [LETTER_W-1:0] last_q;
  logic [LETTER_W-1:0] ring_rd;
  logic [LETTER_W-1:0] leave_code;

  // pattern letters only before any text, and only up to the ring depth
  assign pat_go       = in_go & is_pat & (fill_q == '0) & (plen_q < LEN_W'(MAX_PATTERN));
  assign text_go      = in_go & is_text;
  assign text_live    = text_go & (plen_q != '0);
  assign win_full_now = fill_q == plen_q;
  assign slide        = text_live & win_full_now;
  // a one-letter window leaves the letter written just before: ring read is stale
  assign leave_code   = (plen_q == LEN_W'(1)) ? last_q : ring_rd;

  // ---------------------------------------------------------- window state
  always_comb begin
    plen_d = plen_q;
    fill_d = fill_q;
    ring_d = ring_q;
    if (in_go && is_clear) begin
      plen_d = '0;
      fill_d = '0;
      ring_d = '0;
    end else begin
      if (pat_go) begin
        plen_d = plen_q + LEN_W'(1);
      end
      if (text_live) begin
        if (!win_full_now) begin
          fill_d = fill_q + LEN_W'(1);
        end
        ring_d = (ring_q == RING_W'(MAX_PATTERN - 1)) ? '0 : ring_q + RING_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0;
      fill_q <= '0;
      ring_q <= '0;
    end else begin
      plen_q <= plen_d;
      fill_q <= fill_d;
      ring_q <= ring_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_live) begin
      last_q <= in_data_i.letter;
    end
  end

  // ------------------------------------------------------------------ ring
  // look-ahead read address: where the letter leaving on the next item sits
  logic [CALC_W-1:0] ring_ext, plen_ext, leave_calc;
  logic [RING_W-1:0] rd_addr;

  assign ring_ext = CALC_W'(ring_d);
  assign plen_ext = CALC_W'(plen_d);

  always_comb begin
    if (ring_ext >= plen_ext) begin
      leave_calc = ring_ext - plen_ext;
    end else begin
      leave_calc = ring_ext + CALC_W'(MAX_PATTERN) - plen_ext;
    end
  end

  assign rd_addr = leave_calc[RING_W-1:0];

  sac_ring #(
    .DEPTH  (MAX_PATTERN),
    .ADDR_W (RING_W)
  ) u_ring (
    .clk_i (clk_i),
    .we_i  (text_live),
    .wa_i  (ring_q),
    .wd_i  (in_data_i.letter),
    .ra_i  (rd_addr),
    .rd_o  (ring_rd)
  );

  // -------------------------------------------------------------- cell row
  cell_ctl_t            cell_ctl [ALPHABET_SIZE];
  logic [ALPHABET_SIZE:0] eq_chain;

  assign eq_chain[0] = 1'b1;

  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
    assign cell_ctl[i].clear   = in_go & is_clear;
    assign cell_ctl[i].pat_add = pat_go & (32'(in_data_i.letter) == i);
    assign cell_ctl[i].win_add = text_live & (32'(in_data_i.letter) == i);
    assign cell_ctl[i].win_sub = slide & (32'(leave_code) == i);

    sac_cell #(
      .CNT_W (LEN_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl[i]),
      .eq_i   (eq_chain[i]),
      .eq_o   (eq_chain[i+1])
    );
  end

  // ------------------------------------------------------- pipeline stages
  logic             s1_vld_q, s1_vld_d;
  logic             s1_full_q, s1_full_d;
  logic             out_valid_q, out_free, s1_move, hit;
  sac_out_t         out_q;
  logic [COUNT_W-1:0] cnt_q, cnt_d, cnt_item;

  assign out_free   = ~out_valid_q | out_ready_i;
  assign s1_move    = s1_vld_q & out_free;
  assign in_ready_o = ~s1_vld_q | out_free;

  // cells already hold this item's window; all equal means no letter differs
  assign hit      = s1_full_q & eq_chain[ALPHABET_SIZE];
  assign cnt_item = (hit && cnt_q != COUNT_MAX) ? cnt_q + COUNT_W'(1) : cnt_q;

  always_comb begin
    s1_vld_d  = s1_vld_q;
    s1_full_d = s1_full_q;
    if (in_ready_o) begin
      s1_vld_d  = text_go;
      s1_full_d = text_live & (fill_d == plen_q);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_go && is_clear) begin
      cnt_d = '0;
    end else if (s1_move) begin
      cnt_d = cnt_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s1_full_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      s1_full_q <= s1_full_d;
      cnt_q     <= cnt_d;
      if (out_free) begin
        out_valid_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.window_full <= s1_full_q;
      out_q.is_match    <= hit;
      out_q.match_count <= cnt_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* design/sac_cell.sv */
// One letter cell: pattern and window counts for a single letter code.
// Depends on sac_pkg (cell_ctl_t). Forwards the running all-equal flag.
`timescale 1ns / 1ps
`default_nettype none

module sac_cell import sac_pkg::*; #(
  parameter int unsigned CNT_W = 11
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cell_ctl_t ctl_i,
  input  wire logic      eq_i,
  output logic           eq_o
);

  logic [CNT_W-1:0] pat_q, pat_d;
  logic [CNT_W-1:0] win_q, win_d;

  always_comb begin
    pat_d = pat_q;
    win_d = win_q;
    if (ctl_i.clear) begin
      pat_d = '0;
      win_d = '0;
    end else begin
      if (ctl_i.pat_add) begin
        pat_d = pat_q + CNT_W'(1);
      end
      unique case ({ctl_i.win_add, ctl_i.win_sub})
        2'b10: win_d = win_q + CNT_W'(1);
        2'b01: win_d = (win_q != '0) ? win_q - CNT_W'(1) : win_q;
        // leaving and entering letter equal: net zero unless already empty
        2'b11: win_d = (win_q != '0) ? win_q : CNT_W'(1);
        default: win_d = win_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      win_q <= '0;
    end else begin
      pat_q <= pat_d;
      win_q <= win_d;
    end
  end

  assign eq_o = eq_i & (pat_q == win_q);

endmodule

`default_nettype wire

/* design/sac_ring.sv */
// Ring of recent text letters: one write port, one read port, registered read.
// Depends on sac_pkg (LETTER_W). Contents undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module sac_ring import sac_pkg::*; #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [ADDR_W-1:0]   wa_i,
  input  wire logic [LETTER_W-1:0] wd_i,
  input  wire logic [ADDR_W-1:0]   ra_i,
  output logic      [LETTER_W-1:0] rd_o
);

  logic [LETTER_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_o <= mem[ra_i];
  end

endmodule

`default_nettype wire

/* design/sac_checker.sv */
// Port-level checker for the sliding anagram counter, bound to the top level.
// Depends on sac_pkg (payload types).
`timescale 1ns / 1ps
`default_nettype none

module sac_port_checker import sac_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire sac_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire sac_out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a match needs a full window
  a_match_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_match |-> out_data_o.window_full)
    else $error("match without full window");

  // a match has always been counted
  a_match_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_match |-> out_data_o.match_count != '0)
    else $error("match with zero count");

  // with the output empty, input is never refused
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused while output empty");

endmodule

bind sliding_anagram_counter sac_port_checker u_sac_checker (.*);

`default_nettype wire
